// ----- hw/rtl/kmsf_pkg.sv -----
// Shared types and constants for the spanning forest block.
`timescale 1ns / 1ps
`default_nettype none
package kmsf_pkg;
    localparam int MAX_VERTICES = 16;
    localparam int VERT_W       = 4;
    localparam int WEIGHT_W     = 16;
    localparam int VCOUNT_W     = 5;
    localparam int QUEUE_DEPTH  = 2;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [VERT_W-1:0]   to;
        logic [VERT_W-1:0]   from;
    } link_t;

    typedef struct packed {
        logic [VCOUNT_W-1:0] vcount;
        logic                in_range;
        logic                last;
        link_t               link;
    } q_beat_t;

    typedef struct packed {
        logic  dropped;
        logic  no_edges;
        logic  last;
        link_t link;
    } result_t;
endpackage
`default_nettype wire

// ----- hw/rtl/kmsf_front.sv -----
// Input side: vertex count register and per-edge range classification.
`timescale 1ns / 1ps
`default_nettype none
module kmsf_front import kmsf_pkg::*; (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [VCOUNT_W-1:0] cfg_wdata,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [23:0]         s_tdata,
    input  wire logic                s_tlast,
    output q_beat_t                  q_beat,
    output logic                     q_push,
    input  wire logic                q_full
);
    localparam int VCW = $clog2(MAX_VERTICES + 1);

    logic [VCOUNT_W-1:0] vcount_reg;
    logic [VCW-1:0]      eff_nv;
    link_t               link_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= VCOUNT_W'(16);
        end else if (cfg_we) begin
            vcount_reg <= cfg_wdata;
        end
    end

    assign eff_nv   = (vcount_reg > MAX_VERTICES) ? VCW'(MAX_VERTICES) : VCW'(vcount_reg);
    assign link_in  = link_t'(s_tdata);
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_beat.vcount   = vcount_reg;
        q_beat.in_range = (link_in.from < eff_nv) && (link_in.to < eff_nv);
        q_beat.last     = s_tlast;
        q_beat.link     = link_in;
    end
endmodule
`default_nettype wire

// ----- hw/rtl/kmsf_queue.sv -----
// Short queue of classified edge beats between front and back.
`timescale 1ns / 1ps
`default_nettype none
module kmsf_queue import kmsf_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  q_beat_t   wr_beat,
    input  wire logic push,
    output logic      full,
    output q_beat_t   rd_beat,
    output logic      valid,
    input  wire logic pop
);
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    q_beat_t        slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_push;
    logic           do_pop;

    assign full    = (count_reg == CW'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign rd_beat = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= wr_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/kmsf_back.sv -----
// Edge store, ordered selection scan, union-find sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
module kmsf_back import kmsf_pkg::*; #(
    parameter int MAX_EDGES    = 64
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  q_beat_t   q_beat,
    input  wire logic q_valid,
    output logic      q_pop,
    output logic      m_tvalid,
    output logic [23:0] m_tdata,
    output logic      m_tlast,
    output logic [1:0] m_tuser,
    input  wire logic m_tready
);
    localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int VIW = $clog2(MAX_VERTICES);
    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int SW  = $clog2(MAX_VERTICES + 1);
    localparam int KW  = WEIGHT_W + ECW;

    typedef enum logic [7:0] {
        ST_LOAD = 8'b0000_0001,
        ST_INIT = 8'b0000_0010,
        ST_SCAN = 8'b0000_0100,
        ST_FIND = 8'b0000_1000,
        ST_COMP = 8'b0001_0000,
        ST_SIZE = 8'b0010_0000,
        ST_JOIN = 8'b0100_0000,
        ST_FIN  = 8'b1000_0000
    } state_t;

    state_t         state_reg;
    link_t          mem [MAX_EDGES];
    logic [VIW-1:0] parent_mem [MAX_VERTICES];
    logic [SW-1:0]  size_mem [MAX_VERTICES];

    logic [ECW-1:0] total_reg;
    logic           drop_reg;
    logic [VCW-1:0] nv_reg;
    logic [ECW-1:0] scan_idx_reg;
    logic           rd_vld_reg;
    logic [ECW-1:0] rd_idx_reg;
    link_t          rd_data_reg;
    logic [KW-1:0]  best_key_reg;
    link_t          best_link_reg;
    logic           have_best_reg;
    logic [KW-1:0]  prev_key_reg;
    logic           have_prev_reg;
    logic [VIW-1:0] r_reg;
    logic [VIW-1:0] v_reg;
    logic [VIW-1:0] ru_reg;
    logic           phase_reg;
    logic [SW-1:0]  sa_reg;
    link_t          pend_reg;
    logic           pend_valid_reg;
    result_t        out_reg;
    logic           out_valid_reg;

    logic [KW-1:0]  rd_key;
    logic [VIW-1:0] par_addr;
    logic [VIW-1:0] par_rd;
    logic [VIW-1:0] size_addr;
    logic [SW-1:0]  size_rd;
    logic           can_push;
    logic           out_load;
    logic [VCW-1:0] last_nv;

    assign rd_key    = {rd_data_reg.weight, rd_idx_reg};
    assign par_addr  = (state_reg == ST_COMP) ? v_reg : r_reg;
    assign par_rd    = parent_mem[par_addr];
    assign size_addr = (state_reg == ST_SIZE) ? ru_reg : r_reg;
    assign size_rd   = size_mem[size_addr];
    assign can_push  = !out_valid_reg || m_tready;
    assign out_load  = ((state_reg == ST_JOIN) && pend_valid_reg && can_push)
                       || ((state_reg == ST_FIN) && can_push);
    assign q_pop     = (state_reg == ST_LOAD) && q_valid;
    assign last_nv   = (q_beat.vcount > MAX_VERTICES) ? VCW'(MAX_VERTICES)
                                                      : VCW'(q_beat.vcount);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.link;
    assign m_tlast  = out_reg.last;
    assign m_tuser  = {out_reg.dropped, out_reg.no_edges};

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[scan_idx_reg[EIW-1:0]];
        if (q_pop && q_beat.in_range && (total_reg < ECW'(MAX_EDGES))) begin
            mem[total_reg[EIW-1:0]] <= q_beat.link;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            total_reg      <= '0;
            drop_reg       <= 1'b0;
            rd_vld_reg     <= 1'b0;
            have_best_reg  <= 1'b0;
            have_prev_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            scan_idx_reg   <= '0;
        end else begin
            if (m_tready && !out_load) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_LOAD: begin
                    if (q_valid) begin
                        if (q_beat.in_range && (total_reg < ECW'(MAX_EDGES))) begin
                            total_reg <= total_reg + 1'b1;
                        end else begin
                            drop_reg <= 1'b1;
                        end
                        if (q_beat.last) begin
                            nv_reg    <= last_nv;
                            state_reg <= ST_INIT;
                        end
                    end
                end
                ST_INIT: begin
                    for (int i = 0; i < MAX_VERTICES; i++) begin
                        if (i < nv_reg) begin
                            parent_mem[i] <= VIW'(i);
                            size_mem[i]   <= SW'(1);
                        end
                    end
                    scan_idx_reg  <= '0;
                    rd_vld_reg    <= 1'b0;
                    have_best_reg <= 1'b0;
                    have_prev_reg <= 1'b0;
                    state_reg     <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (scan_idx_reg < total_reg) begin
                        rd_vld_reg   <= 1'b1;
                        rd_idx_reg   <= scan_idx_reg;
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end else begin
                        rd_vld_reg <= 1'b0;
                    end
                    if (rd_vld_reg) begin
                        if ((!have_prev_reg || rd_key > prev_key_reg)
                            && (!have_best_reg || rd_key < best_key_reg)) begin
                            best_key_reg  <= rd_key;
                            best_link_reg <= rd_data_reg;
                            have_best_reg <= 1'b1;
                        end
                    end else if (scan_idx_reg == total_reg) begin
                        if (!have_best_reg) begin
                            state_reg <= ST_FIN;
                        end else begin
                            prev_key_reg  <= best_key_reg;
                            have_prev_reg <= 1'b1;
                            scan_idx_reg  <= '0;
                            have_best_reg <= 1'b0;
                            if ((best_link_reg.from < nv_reg) && (best_link_reg.to < nv_reg)) begin
                                r_reg     <= VIW'(best_link_reg.from);
                                v_reg     <= VIW'(best_link_reg.from);
                                phase_reg <= 1'b0;
                                state_reg <= ST_FIND;
                            end
                        end
                    end
                end
                ST_FIND: begin
                    if (par_rd == r_reg) begin
                        state_reg <= ST_COMP;
                    end else begin
                        r_reg <= par_rd;
                    end
                end
                ST_COMP: begin
                    if (v_reg != r_reg) begin
                        parent_mem[v_reg] <= r_reg;
                        v_reg             <= par_rd;
                    end else if (!phase_reg) begin
                        ru_reg    <= r_reg;
                        r_reg     <= VIW'(best_link_reg.to);
                        v_reg     <= VIW'(best_link_reg.to);
                        phase_reg <= 1'b1;
                        state_reg <= ST_FIND;
                    end else if (r_reg == ru_reg) begin
                        state_reg <= ST_SCAN;
                    end else begin
                        state_reg <= ST_SIZE;
                    end
                end
                ST_SIZE: begin
                    sa_reg    <= size_rd;
                    state_reg <= ST_JOIN;
                end
                ST_JOIN: begin
                    if (!pend_valid_reg || can_push) begin
                        if (sa_reg > size_rd) begin
                            parent_mem[r_reg] <= ru_reg;
                            size_mem[ru_reg]  <= sa_reg + size_rd;
                        end else begin
                            parent_mem[ru_reg] <= r_reg;
                            size_mem[r_reg]    <= size_rd + sa_reg;
                        end
                        if (pend_valid_reg) begin
                            out_reg.link     <= pend_reg;
                            out_reg.last     <= 1'b0;
                            out_reg.no_edges <= 1'b0;
                            out_reg.dropped  <= drop_reg;
                            out_valid_reg    <= 1'b1;
                        end
                        pend_reg       <= best_link_reg;
                        pend_valid_reg <= 1'b1;
                        state_reg      <= ST_SCAN;
                    end
                end
                ST_FIN: begin
                    if (can_push) begin
                        out_reg.link     <= pend_valid_reg ? pend_reg : '0;
                        out_reg.last     <= 1'b1;
                        out_reg.no_edges <= !pend_valid_reg;
                        out_reg.dropped  <= drop_reg;
                        out_valid_reg    <= 1'b1;
                        pend_valid_reg   <= 1'b0;
                        total_reg        <= '0;
                        drop_reg         <= 1'b0;
                        scan_idx_reg     <= '0;
                        state_reg        <= ST_LOAD;
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/kruskal_minimum_spanning_forest.sv -----
// Top level: minimum spanning forest over a streamed weighted edge list.
// Loading takes one edge beat per cycle while the back end is in its load state; after the last
// beat, each stored edge is picked in weight order by a full pass over the store, plus one empty pass.
// For each edge picked, both endpoints are found and path-compressed; differing roots are joined by size.
// The next graph loads only after the final result is registered.
// Synchronous active-low reset clears control state and sets vertex_count to 16.
`timescale 1ns / 1ps
`default_nettype none
module kruskal_minimum_spanning_forest import kmsf_pkg::*; #(
    parameter int MAX_EDGES    = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [VCOUNT_W-1:0] cfg_wdata,   // vertex_count
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [23:0]         s_tdata,     // edge_from, edge_to, edge_weight
    input  wire logic                s_tlast,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [23:0]              m_tdata,     // tree_from, tree_to, tree_weight
    output logic                     m_tlast,
    output logic [1:0]               m_tuser      // no_edges, dropped
);
    q_beat_t push_beat;
    q_beat_t pop_beat;
    logic    q_push;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;

    kmsf_front u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .q_beat(push_beat), .q_push(q_push), .q_full(q_full)
    );

    kmsf_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .wr_beat(push_beat), .push(q_push), .full(q_full),
        .rd_beat(pop_beat), .valid(q_valid), .pop(q_pop)
    );

    kmsf_back #(.MAX_EDGES(MAX_EDGES)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_beat(pop_beat), .q_valid(q_valid), .q_pop(q_pop),
        .m_tvalid(m_tvalid), .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tuser(m_tuser),
        .m_tready(m_tready)
    );
endmodule
`default_nettype wire

// ----- dv/kruskal_minimum_spanning_forest_tb.sv -----
// Testbench for the spanning forest block: streamed graphs checked against a local predictor.
`timescale 1ns / 1ps
`default_nettype none
module kruskal_minimum_spanning_forest_tb;
    import kmsf_pkg::*;

    localparam int NV_MAX = 16;
    localparam int NE_MAX = 64;

    typedef struct {
        logic [3:0]  from;
        logic [3:0]  to;
        logic [15:0] weight;
        logic        last;
    } edge_beat_t;

    typedef struct {
        logic [3:0]  from;
        logic [3:0]  to;
        logic [15:0] weight;
        logic        last;
        logic        no_edges;
        logic        dropped;
    } forest_edge_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_we = 1'b0;
    logic [VCOUNT_W-1:0] cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [23:0]         s_tdata = '0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [23:0]         m_tdata;
    logic                m_tlast;
    logic [1:0]          m_tuser;

    kruskal_minimum_spanning_forest uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    edge_beat_t   pending_edges[$];
    forest_edge_t expected_forest[$];
    int           errors = 0;
    int           graphs_done = 0;
    int           edges_sent = 0;
    int           forest_edges_seen = 0;

    // predictor state
    logic [3:0]  st_from[NE_MAX];
    logic [3:0]  st_to[NE_MAX];
    logic [15:0] st_weight[NE_MAX];
    int          st_total = 0;
    logic        st_drop = 1'b0;
    logic [4:0]  vcount_reg = 5'd16;
    int          uf_parent[NV_MAX];
    int          uf_size[NV_MAX];

    function automatic int find_root(int v);
        int r;
        int nxt;
        r = v;
        while (uf_parent[r] != r) r = uf_parent[r];
        while (v != r) begin
            nxt = uf_parent[v];
            uf_parent[v] = r;
            v = nxt;
        end
        return r;
    endfunction

    task automatic predict_forest(input edge_beat_t b);
        int nv;
        int order[NE_MAX];
        int i;
        int j;
        int ru;
        int rv;
        int cnt;
        forest_edge_t fe;
        nv = (vcount_reg > NV_MAX) ? NV_MAX : vcount_reg;
        if (b.from < nv && b.to < nv && st_total < NE_MAX) begin
            st_from[st_total] = b.from;
            st_to[st_total] = b.to;
            st_weight[st_total] = b.weight;
            st_total++;
        end else begin
            st_drop = 1'b1;
        end
        if (!b.last) return;
        for (i = 0; i < st_total; i++) begin
            j = i;
            while (j > 0 && st_weight[order[j-1]] > st_weight[i]) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
        end
        for (i = 0; i < nv; i++) begin
            uf_parent[i] = i;
            uf_size[i] = 1;
        end
        cnt = 0;
        for (i = 0; i < st_total; i++) begin
            if (st_from[order[i]] >= nv || st_to[order[i]] >= nv) continue;
            ru = find_root(st_from[order[i]]);
            rv = find_root(st_to[order[i]]);
            if (ru != rv && cnt + 1 < NV_MAX) begin
                if (uf_size[ru] > uf_size[rv]) begin
                    uf_parent[rv] = ru;
                    uf_size[ru] += uf_size[rv];
                end else begin
                    uf_parent[ru] = rv;
                    uf_size[rv] += uf_size[ru];
                end
                fe.from = st_from[order[i]];
                fe.to = st_to[order[i]];
                fe.weight = st_weight[order[i]];
                fe.last = 1'b0;
                fe.no_edges = 1'b0;
                fe.dropped = st_drop;
                expected_forest = {expected_forest, fe};
                cnt++;
            end
        end
        if (cnt == 0) begin
            fe = '{4'd0, 4'd0, 16'd0, 1'b1, 1'b1, st_drop};
            expected_forest = {expected_forest, fe};
        end else begin
            expected_forest[expected_forest.size()-1].last = 1'b1;
        end
        st_total = 0;
        st_drop = 1'b0;
    endtask

    // driver
    int  send_gap = 0;
    edge_beat_t cur_edge;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_forest(cur_edge);
                edges_sent++;
                if (cur_edge.last) graphs_done++;
                pending_edges.pop_front();
                send_gap = $urandom_range(0, 9) < 4 ? 0 : $urandom_range(0, 9);
            end
            if (s_tvalid && !s_tready) begin
                // hold
            end else if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_edges.size() > 0) begin
                cur_edge = pending_edges[0];
                s_tvalid <= 1'b1;
                s_tdata <= {cur_edge.weight, cur_edge.to, cur_edge.from};
                s_tlast <= cur_edge.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    int recv_gap = 0;
    always @(posedge aclk) begin
        forest_edge_t exp_fe;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                forest_edges_seen++;
                if (expected_forest.size() == 0) begin
                    $error("unexpected beat tdata=%h", m_tdata);
                    errors++;
                end else begin
                    exp_fe = expected_forest.pop_front();
                    if (m_tdata[3:0] !== exp_fe.from) begin
                        $error("tree_from exp %0d got %0d", exp_fe.from, m_tdata[3:0]);
                        errors++;
                    end
                    if (m_tdata[7:4] !== exp_fe.to) begin
                        $error("tree_to exp %0d got %0d", exp_fe.to, m_tdata[7:4]);
                        errors++;
                    end
                    if (m_tdata[23:8] !== exp_fe.weight) begin
                        $error("tree_weight exp %0d got %0d", exp_fe.weight, m_tdata[23:8]);
                        errors++;
                    end
                    if (m_tlast !== exp_fe.last) begin
                        $error("last_result exp %0d got %0d", exp_fe.last, m_tlast);
                        errors++;
                    end
                    if (m_tuser[0] !== exp_fe.no_edges) begin
                        $error("no_edges exp %0d got %0d", exp_fe.no_edges, m_tuser[0]);
                        errors++;
                    end
                    if (m_tuser[1] !== exp_fe.dropped) begin
                        $error("dropped exp %0d got %0d", exp_fe.dropped, m_tuser[1]);
                        errors++;
                    end
                end
                recv_gap = $urandom_range(0, 9) < 4 ? 0 : $urandom_range(0, 9);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic add_edge(input int f, input int t, input int w, input bit l);
        edge_beat_t b;
        b.from = 4'(f);
        b.to = 4'(t);
        b.weight = 16'(w);
        b.last = l;
        pending_edges = {pending_edges, b};
    endtask

    task automatic drain_graphs();
        while (pending_edges.size() > 0 || s_tvalid || expected_forest.size() > 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_vcount(input logic [4:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        vcount_reg = v;
    endtask

    task automatic random_graph(input int vmax, input int n_edges);
        int k;
        int hi;
        for (k = 0; k < n_edges; k++) begin
            hi = ($urandom_range(0, 9) == 0) ? 15 : ((vmax > 0) ? vmax - 1 : 0);
            add_edge($urandom_range(0, hi), $urandom_range(0, hi),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                                  : $urandom_range(0, 65535),
                     k == n_edges - 1);
        end
    endtask

    initial begin
        int g;
        int vc;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset count of 16
        add_edge(0, 15, 16'hFFFF, 0);
        add_edge(15, 0, 0, 0);
        add_edge(3, 3, 5, 0);
        add_edge(1, 2, 7, 0);
        add_edge(2, 1, 7, 0);
        add_edge(1, 2, 7, 1);
        add_edge(5, 5, 1, 1);
        drain_graphs();

        write_vcount(5'd1);
        add_edge(0, 0, 4, 0);
        add_edge(0, 1, 2, 1);
        drain_graphs();

        write_vcount(5'd0);
        add_edge(0, 0, 9, 1);
        drain_graphs();

        write_vcount(5'd31);
        for (int k = 0; k < 15; k++) add_edge(k, k + 1, 100 - k, 0);
        add_edge(15, 0, 16'hAAAA, 1);
        drain_graphs();

        // full store: more edges than MAX_EDGES holds; the ones past the store are dropped
        write_vcount(5'd4);
        for (int k = 0; k < 66; k++) add_edge(k % 4, (k + 1) % 4, k % 3, k == 65);
        drain_graphs();

        // random graphs, mostly small
        for (g = 0; g < 40; g++) begin
            vc = (g % 8 == 0) ? 16 : $urandom_range(2, 8);
            if (g % 10 == 3) vc = $urandom_range(17, 31);
            write_vcount(vc[4:0]);
            random_graph(vc > 16 ? 16 : vc, $urandom_range(1, 9));
            drain_graphs();
        end
        write_vcount(5'd16);
        random_graph(16, 20);
        drain_graphs();

        $display("covered %0d graphs, %0d edge beats, %0d forest beats",
                 graphs_done, edges_sent, forest_edges_seen);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
